[hdl/fr_pkg.sv]
// ----------------------------------------------------------------------------
// fr_pkg
// Shared types and constants for the Fresnel reflectance pipeline.
// ----------------------------------------------------------------------------
package fr_pkg;

    localparam int FRAC_BITS = 15;
    localparam int SQRT_STEPS = FRAC_BITS + 1;
    localparam int DIV_STEPS = FRAC_BITS;
    localparam logic [31:0] ONE_Q = 32'(1) << FRAC_BITS;
    localparam logic [31:0] ONE_SQ = 32'(1) << (2 * FRAC_BITS);
    localparam logic [15:0] IDX_ONE = 16'd8192;

    typedef struct packed {
        logic signed [15:0] incident_x;
        logic signed [15:0] incident_y;
        logic signed [15:0] incident_z;
        logic signed [15:0] normal_x;
        logic signed [15:0] normal_y;
        logic signed [15:0] normal_z;
        logic [14:0]        refr_index;
    } fr_in_t;

    typedef struct packed {
        logic [15:0] reflectance;
        logic        total_internal;
    } fr_out_t;

    // Per-item context carried alongside the arithmetic units
    typedef struct packed {
        logic        tir;
        logic        leaving;
        logic [14:0] n;
        logic [15:0] c;
        logic [15:0] aux;
    } fr_side_t;

endpackage

[hdl/fr_front.sv]
// ----------------------------------------------------------------------------
// fr_front
// Dot product, clamp, cosine and 1 - cos^2 radicand, three register stages.
// ----------------------------------------------------------------------------
module fr_front
    import fr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  logic        in_valid,
    input  fr_in_t      in_data,
    output logic        out_valid,
    output logic [31:0] out_rad,
    output fr_side_t    out_side
);

    logic               s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic signed [31:0] p0_reg, p1_reg, p2_reg;
    logic [14:0]        n1_reg;
    fr_side_t           s2_side_reg, s3_side_reg;
    logic [31:0]        rad_reg;

    logic signed [33:0] dot;
    logic signed [33:0] dot_c;
    logic [33:0]        mag;
    fr_side_t           s2_side_next;

    // Clamp to +-1.0 in Q2.30, then take magnitude
    always_comb
    begin
        dot = $signed({{2{p0_reg[31]}}, p0_reg}) + $signed({{2{p1_reg[31]}}, p1_reg})
            + $signed({{2{p2_reg[31]}}, p2_reg});
        if (dot > $signed(34'(ONE_SQ)))
            dot_c = $signed(34'(ONE_SQ));
        else if (dot < -$signed(34'(ONE_SQ)))
            dot_c = -$signed(34'(ONE_SQ));
        else
            dot_c = dot;
        mag = dot_c[33] ? 34'(-dot_c) : 34'(dot_c);
        s2_side_next.tir = 1'b0;
        s2_side_next.leaving = (dot_c > 0);
        s2_side_next.n = (n1_reg == '0) ? 15'd1 : n1_reg;
        s2_side_next.c = mag[FRAC_BITS +: 16];
        s2_side_next.aux = '0;
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p0_reg <= in_data.incident_x * in_data.normal_x;
            p1_reg <= in_data.incident_y * in_data.normal_y;
            p2_reg <= in_data.incident_z * in_data.normal_z;
            n1_reg <= in_data.refr_index;
            s2_side_reg <= s2_side_next;
            s3_side_reg <= s2_side_reg;
            rad_reg <= ONE_SQ - 32'(s2_side_reg.c * s2_side_reg.c);
        end
    end

    assign out_valid = s3_valid_reg;
    assign out_rad = rad_reg;
    assign out_side = s3_side_reg;

endmodule

[hdl/fr_sqrt.sv]
// ----------------------------------------------------------------------------
// fr_sqrt
// Pipelined integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module fr_sqrt
    import fr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  logic        in_valid,
    input  logic [31:0] in_rad,
    input  fr_side_t    in_side,
    output logic        out_valid,
    output logic [15:0] out_root,
    output fr_side_t    out_side
);

    logic        vld_reg  [0:SQRT_STEPS];
    logic [31:0] rem_reg  [0:SQRT_STEPS];
    logic [31:0] res_reg  [0:SQRT_STEPS];
    fr_side_t    side_reg [0:SQRT_STEPS];

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= SQRT_STEPS; k++)
                vld_reg[k] <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= in_valid;
            for (int k = 1; k <= SQRT_STEPS; k++)
                vld_reg[k] <= vld_reg[k-1];
        end
    end

    // One digit step per stage: trial subtract of res + bit
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= in_rad;
            res_reg[0] <= '0;
            side_reg[0] <= in_side;
            for (int k = 1; k <= SQRT_STEPS; k++)
            begin
                side_reg[k] <= side_reg[k-1];
                if (rem_reg[k-1] >= res_reg[k-1] + (32'(1) << (2 * SQRT_STEPS - 2 * k)))
                begin
                    rem_reg[k] <= rem_reg[k-1] - res_reg[k-1]
                                  - (32'(1) << (2 * SQRT_STEPS - 2 * k));
                    res_reg[k] <= (res_reg[k-1] >> 1) + (32'(1) << (2 * SQRT_STEPS - 2 * k));
                end
                else
                begin
                    rem_reg[k] <= rem_reg[k-1];
                    res_reg[k] <= res_reg[k-1] >> 1;
                end
            end
        end
    end

    assign out_valid = vld_reg[SQRT_STEPS];
    assign out_root = res_reg[SQRT_STEPS][15:0];
    assign out_side = side_reg[SQRT_STEPS];

endmodule

[hdl/fr_div.sv]
// ----------------------------------------------------------------------------
// fr_div
// Pipelined fractional divider: num/den in Q.F, saturated to 1.0.
// ----------------------------------------------------------------------------
module fr_div
    import fr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  logic        in_valid,
    input  logic [31:0] in_num,
    input  logic [31:0] in_den,
    input  fr_side_t    in_side,
    output logic        out_valid,
    output logic [15:0] out_quo,
    output fr_side_t    out_side
);

    logic        vld_reg  [0:DIV_STEPS];
    logic [31:0] rem_reg  [0:DIV_STEPS];
    logic [31:0] den_reg  [0:DIV_STEPS];
    logic [14:0] quo_reg  [0:DIV_STEPS];
    logic        sat_reg  [0:DIV_STEPS];
    fr_side_t    side_reg [0:DIV_STEPS];

    logic [32:0] shl [1:DIV_STEPS];

    always_comb
    begin
        for (int k = 1; k <= DIV_STEPS; k++)
            shl[k] = {rem_reg[k-1], 1'b0};
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= DIV_STEPS; k++)
                vld_reg[k] <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= in_valid;
            for (int k = 1; k <= DIV_STEPS; k++)
                vld_reg[k] <= vld_reg[k-1];
        end
    end

    // Restoring division, one quotient bit per stage
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= in_num;
            den_reg[0] <= in_den;
            quo_reg[0] <= '0;
            sat_reg[0] <= (in_den == '0) || (in_num >= in_den);
            side_reg[0] <= in_side;
            for (int k = 1; k <= DIV_STEPS; k++)
            begin
                den_reg[k] <= den_reg[k-1];
                sat_reg[k] <= sat_reg[k-1];
                side_reg[k] <= side_reg[k-1];
                if (shl[k] >= {1'b0, den_reg[k-1]})
                begin
                    rem_reg[k] <= 32'(shl[k] - {1'b0, den_reg[k-1]});
                    quo_reg[k] <= {quo_reg[k-1][13:0], 1'b1};
                end
                else
                begin
                    rem_reg[k] <= shl[k][31:0];
                    quo_reg[k] <= {quo_reg[k-1][13:0], 1'b0};
                end
            end
        end
    end

    assign out_valid = vld_reg[DIV_STEPS];
    assign out_quo = sat_reg[DIV_STEPS] ? ONE_Q[15:0] : {1'b0, quo_reg[DIV_STEPS]};
    assign out_side = side_reg[DIV_STEPS];

endmodule

[hdl/fresnel_reflectance.sv]
// Structure: front end, square root for sin_i, Snell divider, square root for cos_t,
// the rs and rp dividers, plus 5 glue stages and the output register.
// Throughput: one transaction per cycle; a stall at the output freezes the
// whole pipeline until the output register drains.
// Reset: rst_n clears all valid bits at once; datapath registers are not reset.
// ----------------------------------------------------------------------------
// fresnel_reflectance
// Unpolarized Fresnel reflectance with total internal reflection detection.
// ----------------------------------------------------------------------------
module fresnel_reflectance
    import fr_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  fr_in_t  in_data,
    output logic    out_valid,
    input  logic    out_ready,
    output fr_out_t out_data
);

    logic        en;
    logic        fe_valid, sq1_valid, dv1_valid, sq2_valid, dvs_valid, dvp_valid;
    logic [31:0] fe_rad;
    fr_side_t    fe_side, sq1_side, dv1_side, sq2_side, dvs_side, dvp_side;
    logic [15:0] sin_i, sin_t_div, cos_t, rs, rp;

    logic        pr_valid_reg, st_valid_reg, pd_valid_reg, sm_valid_reg, sq_valid_reg;
    logic [31:0] pr_num_reg, pr_den_reg;
    fr_side_t    pr_side_reg, st_side_reg, pd_side_reg, sm_side_reg, sq_side_reg;
    logic [31:0] st_rad_reg;
    logic [31:0] etc_reg, eicos_reg, eic_reg, etcos_reg;
    logic [31:0] rs_num_reg, rs_den_reg, rp_num_reg, rp_den_reg;
    logic [31:0] rs2_reg, rp2_reg;
    logic        out_valid_reg;
    fr_out_t     out_data_reg;

    logic [29:0] lv_prod;
    logic [15:0] sin_t;
    logic [15:0] ei, et;
    logic [31:0] kr_sum;
    fr_side_t    pr_side_next, st_side_next;
    fr_out_t     out_data_next;

    // Whole pipeline advances when the output register is free or drained
    assign en = !out_valid_reg || out_ready;
    assign in_ready = en;

    fr_front u_front (
        .clk, .rst_n, .en, .in_valid, .in_data,
        .out_valid(fe_valid), .out_rad(fe_rad), .out_side(fe_side)
    );

    fr_sqrt u_sqrt_sin (
        .clk, .rst_n, .en, .in_valid(fe_valid), .in_rad(fe_rad), .in_side(fe_side),
        .out_valid(sq1_valid), .out_root(sin_i), .out_side(sq1_side)
    );

    // Snell prep: leaving path by multiply, entering path by divider
    always_comb
    begin
        lv_prod = 30'(sin_i) * 30'(sq1_side.n);
        pr_side_next = sq1_side;
        pr_side_next.aux = (lv_prod[29:13] >= 17'(ONE_Q)) ? ONE_Q[15:0] : lv_prod[28:13];
    end

    fr_div u_div_sin (
        .clk, .rst_n, .en, .in_valid(pr_valid_reg), .in_num(pr_num_reg),
        .in_den(pr_den_reg), .in_side(pr_side_reg),
        .out_valid(dv1_valid), .out_quo(sin_t_div), .out_side(dv1_side)
    );

    // Transmitted sine, TIR decision, radicand for cos_t
    always_comb
    begin
        sin_t = dv1_side.leaving ? dv1_side.aux : sin_t_div;
        st_side_next = dv1_side;
        st_side_next.tir = sin_t[15];
    end

    fr_sqrt u_sqrt_cos (
        .clk, .rst_n, .en, .in_valid(st_valid_reg), .in_rad(st_rad_reg),
        .in_side(st_side_reg),
        .out_valid(sq2_valid), .out_root(cos_t), .out_side(sq2_side)
    );

    // Index roles swap when leaving the material
    always_comb
    begin
        ei = sq2_side.leaving ? {1'b0, sq2_side.n} : IDX_ONE;
        et = sq2_side.leaving ? IDX_ONE : {1'b0, sq2_side.n};
    end

    fr_div u_div_rs (
        .clk, .rst_n, .en, .in_valid(sm_valid_reg), .in_num(rs_num_reg),
        .in_den(rs_den_reg), .in_side(sm_side_reg),
        .out_valid(dvs_valid), .out_quo(rs), .out_side(dvs_side)
    );

    fr_div u_div_rp (
        .clk, .rst_n, .en, .in_valid(sm_valid_reg), .in_num(rp_num_reg),
        .in_den(rp_den_reg), .in_side(sm_side_reg),
        .out_valid(dvp_valid), .out_quo(rp), .out_side(dvp_side)
    );

    // Final mean of squares, saturate, TIR override
    always_comb
    begin
        kr_sum = rs2_reg + rp2_reg;
        out_data_next.total_internal = sq_side_reg.tir;
        if (sq_side_reg.tir || (kr_sum[31:2 * FRAC_BITS + 1 - 15] >= ONE_Q))
            out_data_next.reflectance = ONE_Q[15:0];
        else
            out_data_next.reflectance = kr_sum[2 * FRAC_BITS + 1 - 15 +: 16];
    end

    // Valid bits of the glue stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pr_valid_reg  <= 1'b0;
            st_valid_reg  <= 1'b0;
            pd_valid_reg  <= 1'b0;
            sm_valid_reg  <= 1'b0;
            sq_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            pr_valid_reg  <= sq1_valid;
            st_valid_reg  <= dv1_valid;
            pd_valid_reg  <= sq2_valid;
            sm_valid_reg  <= pd_valid_reg;
            sq_valid_reg  <= dvs_valid && dvp_valid;
            out_valid_reg <= sq_valid_reg;
        end
    end

    // Glue datapath
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pr_num_reg  <= 32'(sin_i);
            pr_den_reg  <= {15'd0, sq1_side.n, 2'b00};
            pr_side_reg <= pr_side_next;

            st_rad_reg  <= ONE_SQ - 32'(sin_t * sin_t);
            st_side_reg <= st_side_next;

            etc_reg     <= et * sq2_side.c;
            eicos_reg   <= ei * cos_t;
            eic_reg     <= ei * sq2_side.c;
            etcos_reg   <= et * cos_t;
            pd_side_reg <= sq2_side;

            rs_num_reg  <= (etc_reg >= eicos_reg) ? etc_reg - eicos_reg : eicos_reg - etc_reg;
            rs_den_reg  <= etc_reg + eicos_reg;
            rp_num_reg  <= (eic_reg >= etcos_reg) ? eic_reg - etcos_reg : etcos_reg - eic_reg;
            rp_den_reg  <= eic_reg + etcos_reg;
            sm_side_reg <= pd_side_reg;

            rs2_reg     <= rs * rs;
            rp2_reg     <= rp * rp;
            sq_side_reg <= dvs_side;

            out_data_reg <= out_data_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data = out_data_reg;

`ifndef SYNTHESIS
    a_tir_one: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.total_internal |-> out_data.reflectance == ONE_Q[15:0])
        else $error("TIR result not 1.0");
    a_kr_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.reflectance <= ONE_Q[15:0])
        else $error("reflectance above 1.0");
    a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |=> $stable(sq_valid_reg) && $stable(out_data_reg))
        else $error("pipeline moved during stall");
    a_lanes: assert property (@(posedge clk) disable iff (!rst_n)
        (dvs_valid == dvp_valid) && (!dvs_valid || dvp_side == dvs_side))
        else $error("ratio dividers out of step");
`endif

endmodule
